// ===== rtl/core/cts_pkg.sv =====
// Package for the calendar timestamp stepper: item types, stage records, constants.
package cts_pkg;

   // Step unit codes held in the unit mode register; code three acts as microsecond.
   typedef enum logic [1:0] {
      UNIT_DAY    = 2'd0,
      UNIT_SECOND = 2'd1,
      UNIT_MICRO  = 2'd2
   } unit_type;

   // Command codes
   localparam logic CMD_NEXT = 1'b0;
   localparam logic CMD_PREV = 1'b1;

   localparam logic [19:0]        MAX_USEC   = 20'd999999;
   localparam logic [5:0]         MAX_SEC    = 6'd59;
   localparam logic [5:0]         MAX_MIN    = 6'd59;
   localparam logic [4:0]         MAX_HOUR   = 5'd23;
   localparam logic [3:0]         LAST_MONTH = 4'd12;
   localparam logic [3:0]         FIRST_MONTH = 4'd1;
   localparam logic [4:0]         FIRST_DAY  = 5'd1;
   localparam logic [4:0]         LAST_DEC_DAY = 5'd31;
   localparam logic signed [15:0] YEAR_MIN   = -16'sd32768;
   localparam logic signed [15:0] YEAR_MAX   = 16'sd32767;

   // |year| / 25 as (|year| * 5243) >> 17, exact for |year| <= 32768
   localparam logic [12:0] RECIP_25    = 13'd5243;
   localparam int          RECIP_SHIFT = 17;

   typedef struct packed {
      logic                command;
      logic                in_null;
      logic signed [15:0]  in_year;
      logic [3:0]          in_month;
      logic [4:0]          in_day;
      logic [4:0]          in_hour;
      logic [5:0]          in_minute;
      logic [5:0]          in_second;
      logic [19:0]         in_microsecond;
   } req_type;

   typedef struct packed {
      logic                out_null;
      logic                bad_input;
      logic signed [15:0]  out_year;
      logic [3:0]          out_month;
      logic [4:0]          out_day;
      logic [4:0]          out_hour;
      logic [5:0]          out_minute;
      logic [5:0]          out_second;
      logic [19:0]         out_microsecond;
   } rsp_type;

   // Stage 1: captured item with fields finer than the unit forced to zero
   typedef struct packed {
      logic                valid;
      logic                prev;
      logic                isnull;
      logic                ge_sec;
      logic                ge_usec;
      logic signed [15:0]  year;
      logic [3:0]          month;
      logic [4:0]          day;
      logic [4:0]          hour;
      logic [5:0]          minute;
      logic [5:0]          second;
      logic [19:0]         usec;
      logic [16:0]         abs_year;
   } front_type;

   // Stage 2: quotient by 25 and time-of-day carry chain
   typedef struct packed {
      logic                valid;
      logic                prev;
      logic                isnull;
      logic                ge_sec;
      logic                ge_usec;
      logic signed [15:0]  year;
      logic [3:0]          month;
      logic [4:0]          day;
      logic [4:0]          hour;
      logic [5:0]          minute;
      logic [5:0]          second;
      logic [19:0]         usec;
      logic [16:0]         abs_year;
      logic [10:0]         quot;
      logic                time_ok;
      logic                c_usec;
      logic                c_sec;
      logic                c_min;
      logic                c_date;
   } mid_type;

   // Stage 3: validation and month lengths
   typedef struct packed {
      logic                valid;
      logic                prev;
      logic                isnull;
      logic                bad;
      logic                ge_sec;
      logic                ge_usec;
      logic signed [15:0]  year;
      logic [3:0]          month;
      logic [4:0]          day;
      logic [4:0]          hour;
      logic [5:0]          minute;
      logic [5:0]          second;
      logic [19:0]         usec;
      logic                c_usec;
      logic                c_sec;
      logic                c_min;
      logic                c_date;
      logic                day_last;
      logic [4:0]          prev_days;
   } chk_type;

   // Month length; month zero stands for December of the year before
   function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
      logic [4:0] d;
      case (month) inside
         4'd2:                   d = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:                d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// ===== rtl/core/cts_front.sv =====
// Stage 1: item capture, unit masking and absolute year.
module cts_front
   import cts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   input  logic [1:0] unit_mode,
   output front_type st_out
);

   front_type st_in, st_ff;
   logic [16:0] year_ext;

   always_comb begin
      st_in          = '0;
      st_in.valid    = accept;
      st_in.prev     = (req_data.command == CMD_PREV);
      st_in.isnull   = req_data.in_null;
      st_in.ge_sec   = (unit_mode != UNIT_DAY);
      st_in.ge_usec  = (unit_mode != UNIT_DAY) && (unit_mode != UNIT_SECOND);
      st_in.year     = req_data.in_year;
      st_in.month    = req_data.in_month;
      st_in.day      = req_data.in_day;
      st_in.hour     = st_in.ge_sec  ? req_data.in_hour        : 5'd0;
      st_in.minute   = st_in.ge_sec  ? req_data.in_minute      : 6'd0;
      st_in.second   = st_in.ge_sec  ? req_data.in_second      : 6'd0;
      st_in.usec     = st_in.ge_usec ? req_data.in_microsecond : 20'd0;
      year_ext       = {req_data.in_year[15], req_data.in_year};
      st_in.abs_year = req_data.in_year[15] ? (~year_ext + 17'd1) : year_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign st_out = st_ff;

endmodule

// ===== rtl/core/cts_scan.sv =====
// Stage 2: reciprocal multiply for the year and time-of-day carry chain.
module cts_scan
   import cts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  front_type st_in_d,
   output mid_type   st_out
);

   mid_type     st_in, st_ff;
   logic [29:0] prod;
   logic        us_end, s_end, mi_end, h_end;

   always_comb begin
      prod   = 30'(st_in_d.abs_year) * 30'(RECIP_25);
      us_end = st_in_d.prev ? (st_in_d.usec == 20'd0)  : (st_in_d.usec == MAX_USEC);
      s_end  = st_in_d.prev ? (st_in_d.second == 6'd0) : (st_in_d.second == MAX_SEC);
      mi_end = st_in_d.prev ? (st_in_d.minute == 6'd0) : (st_in_d.minute == MAX_MIN);
      h_end  = st_in_d.prev ? (st_in_d.hour == 5'd0)   : (st_in_d.hour == MAX_HOUR);

      st_in          = '0;
      st_in.valid    = st_in_d.valid;
      st_in.prev     = st_in_d.prev;
      st_in.isnull   = st_in_d.isnull;
      st_in.ge_sec   = st_in_d.ge_sec;
      st_in.ge_usec  = st_in_d.ge_usec;
      st_in.year     = st_in_d.year;
      st_in.month    = st_in_d.month;
      st_in.day      = st_in_d.day;
      st_in.hour     = st_in_d.hour;
      st_in.minute   = st_in_d.minute;
      st_in.second   = st_in_d.second;
      st_in.usec     = st_in_d.usec;
      st_in.abs_year = st_in_d.abs_year;
      st_in.quot     = prod[RECIP_SHIFT +: 11];
      st_in.time_ok  = (st_in_d.hour <= MAX_HOUR) && (st_in_d.minute <= MAX_MIN)
                       && (st_in_d.second <= MAX_SEC) && (st_in_d.usec <= MAX_USEC);
      st_in.c_usec   = !st_in_d.ge_usec || us_end;
      st_in.c_sec    = st_in.c_usec && (!st_in_d.ge_sec || s_end);
      st_in.c_min    = st_in.c_sec  && (!st_in_d.ge_sec || mi_end);
      st_in.c_date   = st_in.c_min  && (!st_in_d.ge_sec || h_end);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign st_out = st_ff;

endmodule

// ===== rtl/core/cts_check.sv =====
// Stage 3: leap year, month lengths and validation.
module cts_check
   import cts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  mid_type st_in_d,
   output chk_type st_out
);

   chk_type     st_in, st_ff;
   logic [16:0] q25;
   logic        div25, leap, date_ok;
   logic [4:0]  mdays;

   always_comb begin
      q25   = 17'({st_in_d.quot, 4'b0000}) + 17'({st_in_d.quot, 3'b000})
              + 17'(st_in_d.quot);
      div25 = (q25 == st_in_d.abs_year);
      // divisible by 4, and not by 100 unless by 400 (25 * 16)
      leap  = (st_in_d.year[1:0] == 2'b00) && (!div25 || (st_in_d.year[3:0] == 4'b0000));
      mdays = days_in(leap, st_in_d.month);
      date_ok = (st_in_d.month >= FIRST_MONTH) && (st_in_d.month <= LAST_MONTH)
                && (st_in_d.day >= FIRST_DAY) && (st_in_d.day <= mdays);

      st_in           = '0;
      st_in.valid     = st_in_d.valid;
      st_in.prev      = st_in_d.prev;
      st_in.isnull    = st_in_d.isnull;
      st_in.bad       = !(date_ok && st_in_d.time_ok);
      st_in.ge_sec    = st_in_d.ge_sec;
      st_in.ge_usec   = st_in_d.ge_usec;
      st_in.year      = st_in_d.year;
      st_in.month     = st_in_d.month;
      st_in.day       = st_in_d.day;
      st_in.hour      = st_in_d.hour;
      st_in.minute    = st_in_d.minute;
      st_in.second    = st_in_d.second;
      st_in.usec      = st_in_d.usec;
      st_in.c_usec    = st_in_d.c_usec;
      st_in.c_sec     = st_in_d.c_sec;
      st_in.c_min     = st_in_d.c_min;
      st_in.c_date    = st_in_d.c_date;
      st_in.day_last  = (st_in_d.day >= mdays);
      st_in.prev_days = days_in(leap, st_in_d.month - 4'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.valid <= 1'b0;
      end else begin
         st_ff <= st_in;
      end
   end

   assign st_out = st_ff;

endmodule

// ===== rtl/core/cts_step.sv =====
// Stage 4: step the fields, range limits and result register.
module cts_step
   import cts_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  chk_type st_in_d,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   rsp_type res_in, res_ff;
   logic    rsp_valid_ff;
   logic    beyond;
   logic    p;

   always_comb begin
      p = st_in_d.prev;
      beyond = p ? ((st_in_d.year == YEAR_MIN) && (st_in_d.month == FIRST_MONTH)
                    && (st_in_d.day == FIRST_DAY) && st_in_d.c_date)
                 : ((st_in_d.year == YEAR_MAX) && (st_in_d.month == LAST_MONTH)
                    && (st_in_d.day == LAST_DEC_DAY) && st_in_d.c_date);

      res_in = '0;
      if (st_in_d.isnull || (!st_in_d.bad && beyond)) begin
         res_in.out_null = 1'b1;
      end else if (st_in_d.bad) begin
         res_in.bad_input = 1'b1;
      end else begin
         // time of day
         if (!st_in_d.ge_usec) begin
            res_in.out_microsecond = 20'd0;
         end else if (st_in_d.c_usec) begin
            res_in.out_microsecond = p ? MAX_USEC : 20'd0;
         end else begin
            res_in.out_microsecond = p ? st_in_d.usec - 20'd1 : st_in_d.usec + 20'd1;
         end

         if (st_in_d.ge_sec && st_in_d.c_usec) begin
            if (st_in_d.c_sec) res_in.out_second = p ? MAX_SEC : 6'd0;
            else res_in.out_second = p ? st_in_d.second - 6'd1 : st_in_d.second + 6'd1;
         end else begin
            res_in.out_second = st_in_d.second;
         end

         if (st_in_d.ge_sec && st_in_d.c_sec) begin
            if (st_in_d.c_min) res_in.out_minute = p ? MAX_MIN : 6'd0;
            else res_in.out_minute = p ? st_in_d.minute - 6'd1 : st_in_d.minute + 6'd1;
         end else begin
            res_in.out_minute = st_in_d.minute;
         end

         if (st_in_d.ge_sec && st_in_d.c_min) begin
            if (st_in_d.c_date) res_in.out_hour = p ? MAX_HOUR : 5'd0;
            else res_in.out_hour = p ? st_in_d.hour - 5'd1 : st_in_d.hour + 5'd1;
         end else begin
            res_in.out_hour = st_in_d.hour;
         end

         // date
         res_in.out_year  = st_in_d.year;
         res_in.out_month = st_in_d.month;
         res_in.out_day   = st_in_d.day;
         if (st_in_d.c_date) begin
            if (!p) begin
               if (st_in_d.day_last) begin
                  res_in.out_day = FIRST_DAY;
                  if (st_in_d.month == LAST_MONTH) begin
                     res_in.out_month = FIRST_MONTH;
                     res_in.out_year  = st_in_d.year + 16'sd1;
                  end else begin
                     res_in.out_month = st_in_d.month + 4'd1;
                  end
               end else begin
                  res_in.out_day = st_in_d.day + 5'd1;
               end
            end else begin
               if (st_in_d.day == FIRST_DAY) begin
                  res_in.out_day = st_in_d.prev_days;
                  if (st_in_d.month == FIRST_MONTH) begin
                     res_in.out_month = LAST_MONTH;
                     res_in.out_year  = st_in_d.year - 16'sd1;
                  end else begin
                     res_in.out_month = st_in_d.month - 4'd1;
                  end
               end else begin
                  res_in.out_day = st_in_d.day - 5'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= st_in_d.valid;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = res_ff;

endmodule

// ===== rtl/core/calendar_timestamp_step.sv =====
// Top level of the calendar timestamp stepper: unit register and four-stage pipeline.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ------------------------------------
//   request   start, busy, req_data          taken when start & !busy
//   result    rsp_valid, rsp_data            one-cycle strobe, cannot be held off
//   csr       csr_valid, csr_ready, csr_data written when csr_valid & csr_ready
//
// Four register stages, and one item per cycle is sustained while reset is low. The
// stages are: capture/mask, year reciprocal multiply and time carry chain, leap year
// and validation, field stepping into the result reg.
// Synchronous active-high reset empties the pipeline and sets the unit to
// microsecond; busy is high only while reset is held. The result side has no
// backpressure, so the pipeline never stalls.
module calendar_timestamp_step
   import cts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_data
);

   logic [1:0] unit_mode_ff, unit_mode_in;
   logic       accept;
   front_type  front_st;
   mid_type    mid_st;
   chk_type    chk_st;

   // items are refused only while reset is applied
   assign busy      = reset;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // unit register: code three behaves as microsecond downstream
   assign unit_mode_in = (csr_valid && csr_ready) ? csr_data : unit_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_mode_ff <= UNIT_MICRO;
      end else begin
         unit_mode_ff <= unit_mode_in;
      end
   end

   // stage 1: capture, drop fields finer than the unit, |year|
   cts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .unit_mode (unit_mode_ff),
      .st_out    (front_st)
   );

   // stage 2: |year| / 25 by reciprocal, wrap flags of the time fields
   cts_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .st_in_d (front_st),
      .st_out  (mid_st)
   );

   // stage 3: leap year, month length, validation
   cts_check u_check (
      .clock   (clock),
      .reset   (reset),
      .st_in_d (mid_st),
      .st_out  (chk_st)
   );

   // stage 4: carry/borrow into the date, range ends, result register
   cts_step u_step (
      .clock     (clock),
      .reset     (reset),
      .st_in_d   (chk_st),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/cts_checker.sv =====
// Port-level checker for the calendar timestamp stepper, with its bind.
module cts_checker
   import cts_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // every accepted item produces a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted item produced no result after 4 cycles");

   // no result strobe without an accepted item
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##4 !rsp_valid)
      else $error("result strobe without an accepted item");

   // null and bad results carry zero fields and never both flags
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_null || rsp_data.bad_input)) |->
         (!(rsp_data.out_null && rsp_data.bad_input) && rsp_data.out_year == 16'sd0
          && rsp_data.out_month == 4'd0 && rsp_data.out_day == 5'd0
          && rsp_data.out_hour == 5'd0 && rsp_data.out_minute == 6'd0
          && rsp_data.out_second == 6'd0 && rsp_data.out_microsecond == 20'd0))
      else $error("flagged result with nonzero fields");

   // a stepped timestamp has its fields in range; the day is checked only from below
   a_legal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.out_null && !rsp_data.bad_input) |->
         (rsp_data.out_month >= FIRST_MONTH && rsp_data.out_month <= LAST_MONTH
          && rsp_data.out_day >= FIRST_DAY && rsp_data.out_hour <= MAX_HOUR
          && rsp_data.out_minute <= MAX_MIN && rsp_data.out_second <= MAX_SEC
          && rsp_data.out_microsecond <= MAX_USEC))
      else $error("stepped timestamp out of range");

endmodule

bind calendar_timestamp_step cts_checker u_cts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
